// ===== design/ttgr_pkg.sv =====
// ----------------------------------------------------------------------------
// ttgr_pkg
// Shared types, constants and helpers of the text terminal glyph rasterizer.
// ----------------------------------------------------------------------------
package ttgr_pkg;

    // screen and cell geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int CELL_W        = 6;
    localparam int CELL_H        = 8;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_COUNT   = 43;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int COLOR_W = 16;
    localparam int CX_W    = 3;
    localparam int LN_W    = 3;
    localparam int GIDX_W  = 6;

    // control and printable codes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF       = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

    // glyph slots past the digits and letters
    localparam logic [GIDX_W-1:0] G_MINUS = 6'd36;
    localparam logic [GIDX_W-1:0] G_DOT   = 6'd37;
    localparam logic [GIDX_W-1:0] G_COLON = 6'd38;
    localparam logic [GIDX_W-1:0] G_SPACE = 6'd39;
    localparam logic [GIDX_W-1:0] G_GT    = 6'd40;
    localparam logic [GIDX_W-1:0] G_LT    = 6'd41;
    localparam logic [GIDX_W-1:0] G_BLOCK = 6'd42;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [COL_W-1:0]   t_col;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [GIDX_W-1:0]  t_glyph_idx;

    // one byte per glyph column, bit n is cell line n
    typedef logic [0:GLYPH_COLS-1][7:0] t_glyph;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_CLEAR = 1'b1
    } t_kind;

    typedef enum logic {
        REG_FG = 1'b0,
        REG_BG = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAW,
        S_CLEAR
    } t_state;

    typedef struct packed {
        t_kind  kind;
        t_col   x;
        t_row   y;
        t_color color;
        logic   last;
    } t_pix;

    typedef struct packed {
        logic clr;
        t_col col;
        t_row row;
    } t_cursor;

    // map a printable byte to its font slot, lowercase folded
    function automatic t_glyph_idx glyph_index(input t_char ch);
        t_char      c;
        t_glyph_idx g;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        priority if (c >= 8'h30 && c <= 8'h39) g = GIDX_W'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h5A) g = GIDX_W'(c - 8'h41 + 8'd10);
        else if (c == 8'h2D) g = G_MINUS;
        else if (c == 8'h2E) g = G_DOT;
        else if (c == 8'h3A) g = G_COLON;
        else if (c == 8'h20) g = G_SPACE;
        else if (c == 8'h3E) g = G_GT;
        else if (c == 8'h3C) g = G_LT;
        else g = G_BLOCK;
        return g;
    endfunction

    // right edge wrap, then bottom edge check
    function automatic t_cursor edge_fix(input logic [COL_W:0] col,
                                         input logic [ROW_W:0] row);
        logic [COL_W:0]   c;
        logic [ROW_W+1:0] r;
        t_cursor          res;
        c = col;
        r = {1'b0, row};
        if (int'(c) + CELL_W > SCREEN_WIDTH) begin
            c = '0;
            r = r + (ROW_W+2)'(CELL_H);
        end
        res.clr = (int'(r) + CELL_H > SCREEN_HEIGHT);
        res.col = res.clr ? '0 : c[COL_W-1:0];
        res.row = res.clr ? '0 : r[ROW_W-1:0];
        return res;
    endfunction

endpackage

// ===== design/ttgr_char_if.sv =====
// ----------------------------------------------------------------------------
// ttgr_char_if
// Character channel: valid/ready handshake carrying one byte per item.
// ----------------------------------------------------------------------------
interface ttgr_char_if;
    import ttgr_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// ===== design/ttgr_pix_if.sv =====
// ----------------------------------------------------------------------------
// ttgr_pix_if
// Pixel channel: valid/ready handshake carrying pixel writes and clears.
// ----------------------------------------------------------------------------
interface ttgr_pix_if;
    import ttgr_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  item_kind;
    t_col   pixel_x;
    t_row   pixel_y;
    t_color pixel_color;
    logic   last_of_run;

    modport source (output valid, output item_kind, output pixel_x, output pixel_y,
                    output pixel_color, output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input pixel_x, input pixel_y,
                    input pixel_color, input last_of_run, output ready);
endinterface

// ===== design/ttgr_font_rom.sv =====
// ----------------------------------------------------------------------------
// ttgr_font_rom
// 5x7 font store with a registered read, one glyph per entry.
// ----------------------------------------------------------------------------
module ttgr_font_rom (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  ttgr_pkg::t_glyph_idx i_addr,
    output ttgr_pkg::t_glyph     o_data
);
    import ttgr_pkg::*;

    localparam t_glyph FONT [GLYPH_COUNT] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
        '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        // minus, dot, colon, space, greater, less
        '{8'h00, 8'h08, 8'h08, 8'h08, 8'h00}, '{8'h00, 8'h00, 8'h60, 8'h00, 8'h00},
        '{8'h00, 8'h36, 8'h00, 8'h36, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h08, 8'h14, 8'h22, 8'h00}, '{8'h00, 8'h22, 8'h14, 8'h08, 8'h00},
        // solid block for everything else
        '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F}
    };

    t_glyph r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= (int'(i_addr) < GLYPH_COUNT) ? FONT[i_addr] : FONT[G_BLOCK];
        end
    end

    assign o_data = r_data;

endmodule

// ===== design/text_terminal_glyph_rasterizer.sv =====
// ----------------------------------------------------------------------------
// text_terminal_glyph_rasterizer
// Character stream in, pixel writes and screen clears out, 5x7 font in a
// 6x8 cell with a wrapping text cursor.
//
// order: a printable item's font store is read on the accept edge, then its
//   first pixel is loaded into the output register once that is free; after
//   that one pixel a cycle while the pixel sink keeps taking them
// occupancy: no new character is taken until a printable item's font read is
//   done and its 48 pixels and any bottom-edge clear have entered the single
//   output register; a control byte holds the block only for its clear
// reset: synchronous active-low; cursor homed, colors white on black, no item
// ----------------------------------------------------------------------------
module text_terminal_glyph_rasterizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ttgr_pkg::t_reg_idx i_cfg_idx,
    input  ttgr_pkg::t_color   i_cfg_data,
    ttgr_char_if.sink          i_char,
    ttgr_pix_if.source         o_pix
);
    import ttgr_pkg::*;

    // control state
    t_state r_state, n_state;
    t_col   r_col, n_col;
    t_row   r_row, n_row;
    logic [CX_W-1:0] r_cx, n_cx;
    logic [LN_W-1:0] r_ln, n_ln;

    // configuration registers
    t_color r_fg;
    t_color r_bg;

    // output register
    logic r_out_valid;
    t_pix r_out;

    // datapath
    logic       char_ready;
    logic       accept;
    logic       is_print;
    logic       rom_rd;
    t_glyph     glyph;
    logic       out_free;
    logic       emit;
    t_pix       emit_item;
    t_cursor    fix;
    logic [COL_W:0] fix_col;
    logic [ROW_W:0] fix_row;
    logic [CX_W-1:0] col_sel;
    logic       pix_on;

    assign accept   = i_char.valid && char_ready;
    assign is_print = (i_char.char_code >= CH_PRINT_LO) && (i_char.char_code <= CH_PRINT_HI);
    assign out_free = !r_out_valid || o_pix.ready;

    // glyph fetched on the accept edge, held for the whole cell
    ttgr_font_rom u_font (
        .i_clk   (i_clk),
        .i_rd_en (rom_rd),
        .i_addr  (glyph_index(i_char.char_code)),
        .o_data  (glyph)
    );

    // column 5 of the cell is spacing, always background
    assign col_sel = (int'(r_cx) < GLYPH_COLS) ? r_cx : '0;
    assign pix_on  = (int'(r_cx) < GLYPH_COLS) && glyph[col_sel][r_ln];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_cx    <= '0;
            r_ln    <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cx    <= n_cx;
            r_ln    <= n_ln;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= '1;
            r_bg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FG: r_fg <= i_cfg_data;
                REG_BG: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register: loads while empty or while its item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_item;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_cx       = r_cx;
        n_ln       = r_ln;
        char_ready = 1'b0;
        rom_rd     = 1'b0;
        emit       = 1'b0;
        emit_item  = '{kind: KIND_PIXEL, x: '0, y: '0, color: r_bg, last: 1'b0};
        fix_col    = {1'b0, r_col};
        fix_row    = {1'b0, r_row};
        fix        = edge_fix(fix_col, fix_row);

        unique case (r_state)
            S_IDLE: begin
                char_ready = 1'b1;
                if (accept) begin
                    priority if (i_char.char_code == CH_FF) begin
                        n_col   = '0;
                        n_row   = '0;
                        n_state = S_CLEAR;
                    end else if (i_char.char_code == CH_CR) begin
                        // return skips the edge checks
                        n_col = '0;
                    end else if (is_print) begin
                        rom_rd  = 1'b1;
                        n_cx    = '0;
                        n_ln    = '0;
                        n_state = S_DRAW;
                    end else begin
                        // newline, backspace and non-printing bytes
                        if (i_char.char_code == CH_LF) begin
                            fix_col = '0;
                            fix_row = {1'b0, r_row} + (ROW_W+1)'(CELL_H);
                        end else if (i_char.char_code == CH_BS &&
                                     int'(r_col) >= CELL_W) begin
                            fix_col = {1'b0, r_col - COL_W'(CELL_W)};
                        end
                        fix   = edge_fix(fix_col, fix_row);
                        n_col = fix.col;
                        n_row = fix.row;
                        if (fix.clr) n_state = S_CLEAR;
                    end
                end
            end
            S_DRAW: begin
                if (out_free) begin
                    emit            = 1'b1;
                    emit_item.kind  = KIND_PIXEL;
                    emit_item.x     = r_col + COL_W'(r_cx);
                    emit_item.y     = r_row + ROW_W'(r_ln);
                    emit_item.color = pix_on ? r_fg : r_bg;
                    if (r_cx == CX_W'(CELL_W - 1)) begin
                        n_cx = '0;
                        if (r_ln == LN_W'(CELL_H - 1)) begin
                            // cell done: advance, wrap, maybe clear
                            fix_col = {1'b0, r_col} + (COL_W+1)'(CELL_W);
                            fix     = edge_fix(fix_col, fix_row);
                            n_col   = fix.col;
                            n_row   = fix.row;
                            emit_item.last = !fix.clr;
                            n_state = fix.clr ? S_CLEAR : S_IDLE;
                        end else begin
                            n_ln = r_ln + 1'b1;
                        end
                    end else begin
                        n_cx = r_cx + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                if (out_free) begin
                    emit            = 1'b1;
                    emit_item.kind  = KIND_CLEAR;
                    emit_item.color = r_bg;
                    emit_item.last  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_char.ready      = char_ready;
    assign o_pix.valid       = r_out_valid;
    assign o_pix.item_kind   = r_out.kind;
    assign o_pix.pixel_x     = r_out.x;
    assign o_pix.pixel_y     = r_out.y;
    assign o_pix.pixel_color = r_out.color;
    assign o_pix.last_of_run = r_out.last;

    // cursor always leaves room for a whole cell
    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) + CELL_W <= SCREEN_WIDTH) && (int'(r_row) + CELL_H <= SCREEN_HEIGHT))
        else $error("cursor outside screen");

    // a clear is always the closing item of its run and sits at the origin
    a_clear_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.item_kind == KIND_CLEAR) |->
        (o_pix.pixel_x == '0 && o_pix.pixel_y == '0 && o_pix.last_of_run))
        else $error("malformed clear item");

    // pixel writes land on the screen
    a_pixel_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.item_kind == KIND_PIXEL) |->
        (int'(o_pix.pixel_x) < SCREEN_WIDTH && int'(o_pix.pixel_y) < SCREEN_HEIGHT))
        else $error("pixel off screen");

    // a printable accept always starts the cell walk at its origin
    a_draw_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_print) |=> (r_state == S_DRAW && r_cx == '0 && r_ln == '0))
        else $error("cell walk did not start");

    // walk counters stay inside the cell
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |-> (int'(r_cx) < CELL_W && int'(r_ln) < CELL_H))
        else $error("cell walk out of range");

endmodule

// ===== dv/ttgr_raster_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttgr_raster_checker
// Watches the character and pixel channels of the glyph rasterizer, works out
// the pixel writes and screen clears each accepted character should cause and
// compares every result, field by field, against the oldest one still due.
// ----------------------------------------------------------------------------
module ttgr_raster_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ttgr_pkg::t_reg_idx i_cfg_idx,
    input  ttgr_pkg::t_color   i_cfg_data,
    ttgr_char_if               i_char,
    ttgr_pix_if                i_pix,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_pixels_seen,
    output int                 o_clears_seen
);
    import ttgr_pkg::*;

    localparam t_color FG_AT_RESET = 16'hFFFF;
    localparam t_color BG_AT_RESET = 16'h0000;

    t_glyph font_rom [36];
    t_color fg_color;
    t_color bg_color;
    int     cur_col;
    int     cur_row;
    t_pix   pixels_due [$];
    int     fails;
    int     pixels_seen;
    int     clears_seen;

    initial begin
        // digits then letters, leftmost column in the top byte
        font_rom = '{
            40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
            40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
            40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
            40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
            40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
            40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
            40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
            40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
            40'h7F2018207F, 40'h6314081463, 40'h0708700807, 40'h6151494543
        };
        fails         = 0;
        pixels_seen   = 0;
        clears_seen   = 0;
        o_fail_count  <= 0;
        o_pending     <= 0;
        o_pixels_seen <= 0;
        o_clears_seen <= 0;
    end

    function automatic t_glyph glyph_of(input t_char ch);
        t_char  c;
        t_glyph g;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;   // fold lowercase
        if (c >= 8'h30 && c <= 8'h39) begin
            g = font_rom[c - 8'h30];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            g = font_rom[c - 8'h41 + 10];
        end else begin
            case (c)
                8'h2D:   g = {8'h00, 8'h08, 8'h08, 8'h08, 8'h00};
                8'h2E:   g = {8'h00, 8'h00, 8'h60, 8'h00, 8'h00};
                8'h3A:   g = {8'h00, 8'h36, 8'h00, 8'h36, 8'h00};
                8'h20:   g = '0;
                8'h3E:   g = {8'h00, 8'h08, 8'h14, 8'h22, 8'h00};
                8'h3C:   g = {8'h00, 8'h22, 8'h14, 8'h08, 8'h00};
                default: g = {5{8'h7F}};                 // solid block
            endcase
        end
        return g;
    endfunction

    function automatic t_pix clear_item();
        t_pix p;
        p.kind  = KIND_CLEAR;
        p.x     = '0;
        p.y     = '0;
        p.color = bg_color;
        p.last  = 1'b0;
        return p;
    endfunction

    // move the cursor and queue up every result this character causes
    task automatic draw_char(input t_char ch);
        t_pix   run [$];
        t_pix   p;
        t_glyph g;
        logic   lit;
        if (ch == CH_FF) begin
            run.push_back(clear_item());
            cur_col = 0;
            cur_row = 0;
        end else if (ch == CH_CR) begin
            cur_col = 0;
        end else begin
            if (ch == CH_LF) begin
                cur_col = 0;
                cur_row += CELL_H;
            end else if (ch == CH_BS) begin
                if (cur_col >= CELL_W) cur_col -= CELL_W;
            end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
                g = glyph_of(ch);
                for (int ln = 0; ln < CELL_H; ln++) begin
                    for (int cx = 0; cx < CELL_W; cx++) begin
                        lit = 1'b0;
                        if (cx < GLYPH_COLS) lit = g[cx][ln];
                        p.kind  = KIND_PIXEL;
                        p.x     = t_col'(cur_col + cx);
                        p.y     = t_row'(cur_row + ln);
                        p.color = lit ? fg_color : bg_color;
                        p.last  = 1'b0;
                        run.push_back(p);
                    end
                end
                cur_col += CELL_W;
            end
            // right edge wraps to the next cell line
            if (cur_col + CELL_W > SCREEN_WIDTH) begin
                cur_col = 0;
                cur_row += CELL_H;
            end
            // past the bottom edge: clear and home
            if (cur_row + CELL_H > SCREEN_HEIGHT) begin
                run.push_back(clear_item());
                cur_col = 0;
                cur_row = 0;
            end
        end
        foreach (run[i]) begin
            p      = run[i];
            p.last = (i == run.size() - 1);
            pixels_due.push_back(p);
        end
    endtask

    task automatic check_pixel();
        t_pix want;
        if (pixels_due.size() == 0) begin
            $error("unexpected result: kind %0d x %0d y %0d color %h last %0d",
                   i_pix.item_kind, i_pix.pixel_x, i_pix.pixel_y, i_pix.pixel_color,
                   i_pix.last_of_run);
            fails++;
        end else begin
            want = pixels_due.pop_front();
            if (want.kind == KIND_CLEAR) clears_seen++;
            else pixels_seen++;
            if (i_pix.item_kind !== want.kind) begin
                $error("item_kind: expected %0d, got %0d", want.kind, i_pix.item_kind);
                fails++;
            end
            if (i_pix.pixel_x !== want.x) begin
                $error("pixel_x: expected %0d, got %0d", want.x, i_pix.pixel_x);
                fails++;
            end
            if (i_pix.pixel_y !== want.y) begin
                $error("pixel_y: expected %0d, got %0d", want.y, i_pix.pixel_y);
                fails++;
            end
            if (i_pix.pixel_color !== want.color) begin
                $error("pixel_color: expected %h, got %h", want.color, i_pix.pixel_color);
                fails++;
            end
            if (i_pix.last_of_run !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, i_pix.last_of_run);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fg_color = FG_AT_RESET;
            bg_color = BG_AT_RESET;
            cur_col  = 0;
            cur_row  = 0;
            pixels_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FG) fg_color = i_cfg_data;
                else bg_color = i_cfg_data;
            end
            if (i_char.valid && i_char.ready) draw_char(i_char.char_code);
            if (i_pix.valid && i_pix.ready) check_pixel();
        end
        o_fail_count  <= fails;
        o_pending     <= pixels_due.size();
        o_pixels_seen <= pixels_seen;
        o_clears_seen <= clears_seen;
    end

endmodule

// ===== dv/text_terminal_glyph_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_glyph_rasterizer_tb
// Feeds the rasterizer a directed set of characters and then line-shaped
// random text under several color settings, with random gaps on the sender
// and random stalls on the pixel sink; a checker beside the block predicts
// and compares every pixel write and clear.
// ----------------------------------------------------------------------------
module text_terminal_glyph_rasterizer_tb;
    import ttgr_pkg::*;

    localparam int QUIET_LIMIT   = 1000;  // cycles with no handshake or register write
    localparam int SETTLE_CYCLES = 4;     // lets control bytes that cause no result finish

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    t_reg_idx cfg_idx;
    t_color   cfg_data;

    // idling bounds, changed from phase to phase
    int tx_gap_max   = 3;
    int rx_stall_max = 3;

    int chars_sent;
    int printables_sent;
    int settings_used;
    int fail_count;
    int pending;
    int pixels_seen;
    int clears_seen;

    ttgr_char_if char_if ();
    ttgr_pix_if  pix_if ();

    text_terminal_glyph_rasterizer DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_char     (char_if),
        .o_pix      (pix_if)
    );

    ttgr_raster_checker raster_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_char        (char_if),
        .i_pix         (pix_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_pixels_seen (pixels_seen),
        .o_clears_seen (clears_seen)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // character generators
    // ------------------------------------------------------------------------

    function automatic t_char rand_printable();
        return t_char'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    endfunction

    // controls the block does not act on, DEL and the upper half
    function automatic t_char rand_noise();
        t_char c;
        do c = t_char'($urandom_range(0, 255));
        while ((c >= CH_PRINT_LO && c <= CH_PRINT_HI) || c == CH_BS || c == CH_LF ||
               c == CH_FF || c == CH_CR);
        return c;
    endfunction

    // body of a short line: mostly text, some editing, a little noise
    function automatic t_char rand_line_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return rand_printable();
        else if (pick < 83) return CH_BS;
        else if (pick < 88) return CH_CR;
        return rand_noise();
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one item on the character channel; valid stays up across back to back items
    task automatic send_char(input t_char ch);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= ch;
        do @(posedge clk); while (!char_if.ready);
        chars_sent++;
        if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) printables_sent++;
    endtask

    // hold the sender until every due result is back and the block is quiet
    task automatic drain_block();
        char_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers, back to back, only while the block is idle
    task automatic write_colors(input t_color fg, input t_color bg);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_FG;
        cfg_data <= fg;
        @(posedge clk);
        cfg_idx  <= REG_BG;
        cfg_data <= bg;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random text made of lines, with long lines that run past the right
    // edge, newline runs that reach the bottom edge, and the odd form feed
    task automatic type_text(input int budget);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                len = $urandom_range(50, 58);
                repeat (len) send_char(rand_printable());
                sent += len;
            end else if (pick < 14) begin
                len = $urandom_range(5, 30);
                repeat (len) send_char(CH_LF);
                sent += len;
            end else if (pick < 16) begin
                send_char(CH_FF);
                sent++;
            end else if (pick < 18) begin
                drain_block();
            end else begin
                len = $urandom_range(0, 6);
                repeat (len) send_char(rand_line_char());
                send_char(($urandom_range(0, 9) == 0) ? CH_CR : CH_LF);
                sent += len + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // pixel sink: after each taken item, drop ready for a random stall bounded by rx_stall_max
    // ------------------------------------------------------------------------
    initial begin : pixel_sink
        int stall_left;
        pix_if.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                pix_if.ready <= 1'b0;
                stall_left = 0;
            end else if (pix_if.ready) begin
                if (pix_if.valid) begin
                    stall_left = $urandom_range(0, rx_stall_max);
                    if (stall_left > 0) pix_if.ready <= 1'b0;
                end
            end else if (stall_left > 1) begin
                stall_left--;
            end else begin
                pix_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any handshake or register write counts as progress
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (char_if.valid && char_if.ready) ||
                (pix_if.valid && pix_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("text_terminal_glyph_rasterizer_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_char opening [$];

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= REG_FG;
        cfg_data          <= '0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= '0;
        chars_sent      = 0;
        printables_sent = 0;
        settings_used   = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: digit and letter bounds, both cases, every symbol glyph,
        // neighbors that fall to the block, the printable ends, backspace
        // mid-line and at column zero, return, ignored bytes, newline, clear
        opening = '{8'h30, 8'h39, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h2D, 8'h2E, 8'h3A,
                    CH_PRINT_LO, 8'h3E, 8'h3C, 8'h40, 8'h7B, CH_PRINT_HI,
                    CH_BS, CH_CR, CH_BS, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h6D,
                    CH_LF, CH_FF};
        foreach (opening[i]) send_char(opening[i]);
        drain_block();

        // inverted extremes, idling on both sides
        write_colors(16'h0000, 16'hFFFF);
        tx_gap_max   = 8;
        rx_stall_max = 8;
        type_text(20);
        drain_block();

        // full speed: walk down to the last cell line, then type past the
        // right edge so the wrap and the bottom clear land on one character
        write_colors(t_color'($urandom), t_color'($urandom));
        tx_gap_max   = 0;
        rx_stall_max = 0;
        send_char(CH_FF);
        repeat (SCREEN_HEIGHT / CELL_H - 1) send_char(CH_LF);
        repeat (SCREEN_WIDTH / CELL_W + 1) send_char(rand_printable());
        type_text(10);
        drain_block();

        // reset colors written explicitly, sender gaps only
        write_colors(16'hFFFF, 16'h0000);
        tx_gap_max   = 8;
        rx_stall_max = 0;
        type_text(20);
        drain_block();

        // random colors, sink stalls only
        write_colors(t_color'($urandom), t_color'($urandom));
        tx_gap_max   = 0;
        rx_stall_max = 8;
        type_text(20);
        drain_block();

        // random colors, idling everywhere again
        write_colors(t_color'($urandom), t_color'($urandom));
        tx_gap_max   = 8;
        rx_stall_max = 8;
        type_text(20);
        drain_block();

        $display("sent %0d characters (%0d printable) under %0d color settings",
                 chars_sent, printables_sent, settings_used + 1);
        $display("checked %0d pixel writes and %0d screen clears",
                 pixels_seen, clears_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("text_terminal_glyph_rasterizer_tb OK");
        end else begin
            $display("text_terminal_glyph_rasterizer_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ttgr_pkg.sv
design/ttgr_char_if.sv
design/ttgr_pix_if.sv
design/ttgr_font_rom.sv
design/text_terminal_glyph_rasterizer.sv
dv/ttgr_raster_checker.sv
dv/text_terminal_glyph_rasterizer_tb.sv
